// File: hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, the hue sector code and the stage-to-stage words.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W   = 9;
  localparam int LEVEL_W = 8;
  localparam int PROD_W  = 2 * LEVEL_W;
  localparam int WGT_W   = 6;
  localparam int MIX_W   = LEVEL_W + WGT_W;

  localparam logic [HUE_W-1:0] SECTOR_DEG = HUE_W'(60);
  localparam logic [WGT_W-1:0] SECTOR_WGT = WGT_W'(60);

  // Division by 60 for values below 15301 as a multiply and shift.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(17477);

  typedef enum logic [2:0] {
    SEC_RED_YEL   = 3'd0,
    SEC_YEL_GRN   = 3'd1,
    SEC_GRN_CYN   = 3'd2,
    SEC_CYN_BLU   = 3'd3,
    SEC_BLU_MAG   = 3'd4,
    SEC_MAG_RED   = 3'd5,
    SEC_GREY      = 3'd6
  } sector_t;

  typedef struct packed {
    logic                 valid;
    logic [PROD_W-1:0]    prod;
    logic [LEVEL_W-1:0]   val;
    sector_t              sector;
    logic [WGT_W-1:0]     weight;
  } dec_word_t;

  typedef struct packed {
    logic                 valid;
    logic [MIX_W-1:0]     mix;
    logic [LEVEL_W-1:0]   chroma;
    logic [LEVEL_W-1:0]   offset;
    sector_t              sector;
  } chr_word_t;

endpackage

// File: hdl/hsv2rgb_decode.sv
// ----------------------------------------------------------------------------
// HSV to RGB hue decode stage
// Registers V*S together with the hue sector and the secondary weight.
// ----------------------------------------------------------------------------
module hsv2rgb_decode (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue_degrees,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0] saturation_level,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0] value_level,
  output hsv2rgb_pkg::dec_word_t          dec
);
  import hsv2rgb_pkg::*;

  sector_t           sector_next;
  logic [HUE_W-1:0]  base;
  logic [HUE_W-1:0]  pos;
  logic [HUE_W-1:0]  delta;
  logic [WGT_W-1:0]  weight_next;

  always_comb begin
    if (hue_degrees < HUE_W'(60)) begin
      sector_next = SEC_RED_YEL;
    end else if (hue_degrees < HUE_W'(120)) begin
      sector_next = SEC_YEL_GRN;
    end else if (hue_degrees < HUE_W'(180)) begin
      sector_next = SEC_GRN_CYN;
    end else if (hue_degrees < HUE_W'(240)) begin
      sector_next = SEC_CYN_BLU;
    end else if (hue_degrees < HUE_W'(300)) begin
      sector_next = SEC_BLU_MAG;
    end else if (hue_degrees < HUE_W'(360)) begin
      sector_next = SEC_MAG_RED;
    end else begin
      sector_next = SEC_GREY;
    end

    case (sector_next)
      SEC_RED_YEL, SEC_YEL_GRN: base = HUE_W'(0);
      SEC_GRN_CYN, SEC_CYN_BLU: base = HUE_W'(120);
      SEC_BLU_MAG, SEC_MAG_RED: base = HUE_W'(240);
      default:                  base = hue_degrees;
    endcase

    pos = hue_degrees - base;
    if (pos >= SECTOR_DEG) begin
      delta = pos - SECTOR_DEG;
    end else begin
      delta = SECTOR_DEG - pos;
    end
    if (sector_next == SEC_GREY) begin
      weight_next = '0;
    end else begin
      weight_next = SECTOR_WGT - delta[WGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else begin
      dec.valid <= in_valid;
    end
    dec.prod   <= PROD_W'(value_level) * PROD_W'(saturation_level);
    dec.val    <= value_level;
    dec.sector <= sector_next;
    dec.weight <= weight_next;
  end

endmodule

// File: hdl/hsv2rgb_chroma.sv
// ----------------------------------------------------------------------------
// HSV to RGB chroma stages
// Divides V*S by 255 to get chroma and offset, then scales chroma by weight.
// ----------------------------------------------------------------------------
module hsv2rgb_chroma (
  input  logic                   clk,
  input  logic                   rst,
  input  hsv2rgb_pkg::dec_word_t dec,
  output hsv2rgb_pkg::chr_word_t chr
);
  import hsv2rgb_pkg::*;

  logic [PROD_W:0]    quot_sum;
  logic [LEVEL_W-1:0] chroma_next;

  logic               valid2;
  logic [LEVEL_W-1:0] chroma2;
  logic [LEVEL_W-1:0] offset2;
  sector_t            sector2;
  logic [WGT_W-1:0]   weight2;

  // For any p up to 255 * 255, floor(p / 255) equals (p + (p >> 8) + 1) >> 8.
  always_comb begin
    quot_sum    = {1'b0, dec.prod} + (PROD_W+1)'(dec.prod >> LEVEL_W) + (PROD_W+1)'(1);
    chroma_next = quot_sum[PROD_W-1:LEVEL_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2    <= 1'b0;
      chr.valid <= 1'b0;
    end else begin
      valid2    <= dec.valid;
      chr.valid <= valid2;
    end
    chroma2    <= chroma_next;
    offset2    <= dec.val - chroma_next;
    sector2    <= dec.sector;
    weight2    <= dec.weight;
    chr.mix    <= MIX_W'(chroma2) * MIX_W'(weight2);
    chr.chroma <= chroma2;
    chr.offset <= offset2;
    chr.sector <= sector2;
  end

endmodule

// File: hdl/hsv2rgb_mix.sv
// ----------------------------------------------------------------------------
// HSV to RGB mixing stages
// Divides the weighted chroma by 60, then places and offsets the channels.
// ----------------------------------------------------------------------------
module hsv2rgb_mix (
  input  logic                            clk,
  input  logic                            rst,
  input  hsv2rgb_pkg::chr_word_t          chr,
  output logic                            out_valid,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0] red_level,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0] green_level,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0] blue_level
);
  import hsv2rgb_pkg::*;

  logic [MIX_W+RECIP_W-1:0] recip_prod;

  logic               valid4;
  logic [LEVEL_W-1:0] second4;
  logic [LEVEL_W-1:0] chroma4;
  logic [LEVEL_W-1:0] offset4;
  sector_t            sector4;

  logic [LEVEL_W-1:0] red_next;
  logic [LEVEL_W-1:0] green_next;
  logic [LEVEL_W-1:0] blue_next;

  assign recip_prod = (MIX_W+RECIP_W)'(chr.mix) * (MIX_W+RECIP_W)'(RECIP_60);

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    case (sector4)
      SEC_RED_YEL: begin
        red_next   = chroma4;
        green_next = second4;
      end
      SEC_YEL_GRN: begin
        red_next   = second4;
        green_next = chroma4;
      end
      SEC_GRN_CYN: begin
        green_next = chroma4;
        blue_next  = second4;
      end
      SEC_CYN_BLU: begin
        green_next = second4;
        blue_next  = chroma4;
      end
      SEC_BLU_MAG: begin
        red_next  = second4;
        blue_next = chroma4;
      end
      SEC_MAG_RED: begin
        red_next  = chroma4;
        blue_next = second4;
      end
      default: begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid4    <= chr.valid;
      out_valid <= valid4;
    end
    second4     <= recip_prod[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
    chroma4     <= chr.chroma;
    offset4     <= chr.offset;
    sector4     <= chr.sector;
    red_level   <= red_next + offset4;
    green_level <= green_next + offset4;
    blue_level  <= blue_next + offset4;
  end

endmodule

// File: hdl/hsv_to_rgb_converter_core.sv
// An accepted word passes through the decode, chroma and mix register stages to done.
// Throughput: one word per cycle; busy stays low, as the five register stages
// (one multiplier each in stages one, three and four) take a word every clock.
// Reset clears every stage valid bit; no result strobe follows a reset until
// new words are accepted. The receiver cannot stall.
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline that turns one HSV pixel into one 8-bit RGB triple.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue_degrees,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0] saturation_level,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0] value_level,
  output logic                            done,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0] red_level,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0] green_level,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0] blue_level
);
  import hsv2rgb_pkg::*;

  dec_word_t dec;
  chr_word_t chr;

  assign busy = 1'b0;

  hsv2rgb_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (start & ~busy),
    .hue_degrees      (hue_degrees),
    .saturation_level (saturation_level),
    .value_level      (value_level),
    .dec              (dec)
  );

  hsv2rgb_chroma u_chroma (
    .clk (clk),
    .rst (rst),
    .dec (dec),
    .chr (chr)
  );

  hsv2rgb_mix u_mix (
    .clk         (clk),
    .rst         (rst),
    .chr         (chr),
    .out_valid   (done),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level)
  );

endmodule

// File: hdl/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [hsv2rgb_pkg::HUE_W-1:0]   hue_degrees,
  input logic [hsv2rgb_pkg::LEVEL_W-1:0] saturation_level,
  input logic [hsv2rgb_pkg::LEVEL_W-1:0] value_level,
  input logic                            done,
  input logic [hsv2rgb_pkg::LEVEL_W-1:0] red_level,
  input logic [hsv2rgb_pkg::LEVEL_W-1:0] green_level,
  input logic [hsv2rgb_pkg::LEVEL_W-1:0] blue_level
);
  import hsv2rgb_pkg::*;

  a_word_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted word produced no result");

  a_result_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without an accepted word");

  a_no_saturation: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && saturation_level == '0) |-> ##5
      (red_level == $past(value_level, 5) && green_level == $past(value_level, 5)
       && blue_level == $past(value_level, 5)))
    else $error("zero saturation did not give value on all channels");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && hue_degrees >= HUE_W'(360)) |-> ##5
      (red_level == green_level && green_level == blue_level))
    else $error("out-of-range hue did not give grey");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .hue_degrees      (hue_degrees),
  .saturation_level (saturation_level),
  .value_level      (value_level),
  .done             (done),
  .red_level        (red_level),
  .green_level      (green_level),
  .blue_level       (blue_level)
);

// File: sim/hsv_to_rgb_converter_core_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Watches the command and result ports of the converter, predicts the RGB
// triple for every accepted pixel and compares it with the results in order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_chk
  import hsv2rgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [HUE_W-1:0]   hue_degrees,
  input  logic [LEVEL_W-1:0] saturation_level,
  input  logic [LEVEL_W-1:0] value_level,
  input  logic               done,
  input  logic [LEVEL_W-1:0] red_level,
  input  logic [LEVEL_W-1:0] green_level,
  input  logic [LEVEL_W-1:0] blue_level,
  output int                 fail_count,
  output int                 pixels_in_flight
);

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } rgb_t;

  rgb_t rgb_pending[$];
  int   mismatches;

  function automatic rgb_t predict_rgb(logic [HUE_W-1:0] hue, logic [LEVEL_W-1:0] sat,
                                       logic [LEVEL_W-1:0] val);
    int unsigned chroma;
    int unsigned pos;
    int unsigned delta;
    int unsigned side;
    int unsigned offset;
    int unsigned red;
    int unsigned green;
    int unsigned blue;
    sector_t     sector;
    rgb_t        px;
    chroma = (int'(val) * int'(sat)) / 255;
    pos    = int'(hue) % 120;
    delta  = (pos >= 60) ? pos - 60 : 60 - pos;
    side   = (chroma * (60 - delta)) / 60;
    offset = int'(val) - chroma;
    sector = (int'(hue) < 360) ? sector_t'(int'(hue) / 60) : SEC_GREY;
    red    = 0;
    green  = 0;
    blue   = 0;
    case (sector)
      SEC_RED_YEL: begin
        red   = chroma;
        green = side;
      end
      SEC_YEL_GRN: begin
        red   = side;
        green = chroma;
      end
      SEC_GRN_CYN: begin
        green = chroma;
        blue  = side;
      end
      SEC_CYN_BLU: begin
        green = side;
        blue  = chroma;
      end
      SEC_BLU_MAG: begin
        red  = side;
        blue = chroma;
      end
      SEC_MAG_RED: begin
        red  = chroma;
        blue = side;
      end
      default: begin
      end
    endcase
    px.red   = LEVEL_W'(red + offset);
    px.green = LEVEL_W'(green + offset);
    px.blue  = LEVEL_W'(blue + offset);
    return px;
  endfunction

  initial begin
    fail_count       = 0;
    pixels_in_flight = 0;
    mismatches       = 0;
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst) begin
      if (start && !busy) begin
        rgb_pending.push_back(predict_rgb(hue_degrees, saturation_level, value_level));
      end
      if (done === 1'b1) begin
        if (rgb_pending.size() == 0) begin
          fail_count = fail_count + 1;
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("%0t: result word with nothing expected: r=%0d g=%0d b=%0d",
                     $realtime, red_level, green_level, blue_level);
          end
        end else begin
          want = rgb_pending.pop_front();
          if (red_level !== want.red || green_level !== want.green ||
              blue_level !== want.blue) begin
            fail_count = fail_count + 1;
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       red_level, green_level, blue_level);
            end
          end
        end
      end
      pixels_in_flight = rgb_pending.size();
    end
  end

endmodule

// File: sim/hsv_to_rgb_converter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed corner pixels and then random pixels with random gaps into
// the converter, while the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_tb;
  import hsv2rgb_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [HUE_W-1:0]   hue_degrees = '0;
  logic [LEVEL_W-1:0] saturation_level = '0;
  logic [LEVEL_W-1:0] value_level = '0;
  logic               done;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;
  int                 fail_count;
  int                 pixels_in_flight;
  int                 burst_left = 0;

  hsv_to_rgb_converter_core dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .hue_degrees      (hue_degrees),
    .saturation_level (saturation_level),
    .value_level      (value_level),
    .done             (done),
    .red_level        (red_level),
    .green_level      (green_level),
    .blue_level       (blue_level)
  );

  hsv_to_rgb_converter_core_chk chk (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .hue_degrees      (hue_degrees),
    .saturation_level (saturation_level),
    .value_level      (value_level),
    .done             (done),
    .red_level        (red_level),
    .green_level      (green_level),
    .blue_level       (blue_level),
    .fail_count       (fail_count),
    .pixels_in_flight (pixels_in_flight)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #200000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [LEVEL_W-1:0] sat,
                            input logic [LEVEL_W-1:0] val);
    int gap;
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 19) == 0) begin
        burst_left = $urandom_range(10, 40);
      end
    end
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start            <= 1'b1;
    hue_degrees      <= hue;
    saturation_level <= sat;
    value_level      <= val;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    start <= 1'b0;
    wait (pixels_in_flight == 0);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [HUE_W-1:0] hue;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_pixel(9'd0,   8'd255, 8'd255);
    send_pixel(9'd59,  8'd255, 8'd255);
    send_pixel(9'd60,  8'd255, 8'd255);
    send_pixel(9'd119, 8'd255, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd255);
    send_pixel(9'd179, 8'd255, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd239, 8'd255, 8'd255);
    send_pixel(9'd240, 8'd200, 8'd170);
    send_pixel(9'd299, 8'd128, 8'd255);
    send_pixel(9'd300, 8'd255, 8'd127);
    send_pixel(9'd359, 8'd255, 8'd255);
    send_pixel(9'd360, 8'd255, 8'd255);
    send_pixel(9'd511, 8'd100, 8'd200);
    send_pixel(9'd400, 8'd0,   8'd255);
    send_pixel(9'd90,  8'd0,   8'd255);
    send_pixel(9'd30,  8'd0,   8'd0);
    send_pixel(9'd210, 8'd255, 8'd0);
    send_pixel(9'd270, 8'd170, 8'd85);
    send_pixel(9'd330, 8'd1,   8'd1);
    send_pixel(9'd150, 8'd85,  8'd170);
    drain_pixels();

    for (int i = 0; i < 650; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        hue = HUE_W'($urandom_range(360, 511));
      end else begin
        hue = HUE_W'($urandom_range(0, 359));
      end
      send_pixel(hue, pick_level(), pick_level());
      if (i % 200 == 199) begin
        drain_pixels();
      end
    end

    drain_pixels();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
